FILE: rtl/s2a_pkg.sv
// Shared types, codes and key tables for the scancode to ASCII character FIFO.
// No dependencies; every other file refers to this package by scoped names.
package s2a_pkg;

	localparam int FIFO_DEPTH_DEF = 128;
	localparam int CHAR_W         = 7;
	localparam int CODE_W         = 8;

	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [CODE_W-1:0] MAKE_LSHIFT  = 8'h2A;
	localparam logic [CODE_W-1:0] MAKE_RSHIFT  = 8'h36;
	localparam logic [CODE_W-1:0] BREAK_LSHIFT = 8'hAA;
	localparam logic [CODE_W-1:0] BREAK_RSHIFT = 8'hB6;
	localparam logic [6:0]        TABLE_LEN    = 7'd59;

	typedef struct packed {
		logic              req;
		logic [CHAR_W-1:0] ch;
	} push_t;

	typedef struct packed {
		logic              char_valid;
		logic              key_waiting;
		logic [CHAR_W-1:0] character;
	} result_t;

	function automatic logic [CHAR_W-1:0] plain_char(input logic [5:0] idx);
		case (idx)
			6'd1:  plain_char = 7'h1B;
			6'd2:  plain_char = 7'h31;
			6'd3:  plain_char = 7'h32;
			6'd4:  plain_char = 7'h33;
			6'd5:  plain_char = 7'h34;
			6'd6:  plain_char = 7'h35;
			6'd7:  plain_char = 7'h36;
			6'd8:  plain_char = 7'h37;
			6'd9:  plain_char = 7'h38;
			6'd10: plain_char = 7'h39;
			6'd11: plain_char = 7'h30;
			6'd12: plain_char = 7'h2D;
			6'd13: plain_char = 7'h3D;
			6'd14: plain_char = 7'h08;
			6'd15: plain_char = 7'h09;
			6'd16: plain_char = 7'h71;
			6'd17: plain_char = 7'h77;
			6'd18: plain_char = 7'h65;
			6'd19: plain_char = 7'h72;
			6'd20: plain_char = 7'h74;
			6'd21: plain_char = 7'h79;
			6'd22: plain_char = 7'h75;
			6'd23: plain_char = 7'h69;
			6'd24: plain_char = 7'h6F;
			6'd25: plain_char = 7'h70;
			6'd26: plain_char = 7'h5B;
			6'd27: plain_char = 7'h5D;
			6'd28: plain_char = 7'h0A;
			6'd30: plain_char = 7'h61;
			6'd31: plain_char = 7'h73;
			6'd32: plain_char = 7'h64;
			6'd33: plain_char = 7'h66;
			6'd34: plain_char = 7'h67;
			6'd35: plain_char = 7'h68;
			6'd36: plain_char = 7'h6A;
			6'd37: plain_char = 7'h6B;
			6'd38: plain_char = 7'h6C;
			6'd39: plain_char = 7'h3B;
			6'd40: plain_char = 7'h27;
			6'd41: plain_char = 7'h60;
			6'd43: plain_char = 7'h5C;
			6'd44: plain_char = 7'h7A;
			6'd45: plain_char = 7'h78;
			6'd46: plain_char = 7'h63;
			6'd47: plain_char = 7'h76;
			6'd48: plain_char = 7'h62;
			6'd49: plain_char = 7'h6E;
			6'd50: plain_char = 7'h6D;
			6'd51: plain_char = 7'h2C;
			6'd52: plain_char = 7'h2E;
			6'd53: plain_char = 7'h2F;
			6'd55: plain_char = 7'h2A;
			6'd57: plain_char = 7'h20;
			default: plain_char = 7'h00;
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] upper_char(input logic [5:0] idx);
		case (idx)
			6'd1:  upper_char = 7'h1B;
			6'd2:  upper_char = 7'h21;
			6'd3:  upper_char = 7'h40;
			6'd4:  upper_char = 7'h23;
			6'd5:  upper_char = 7'h24;
			6'd6:  upper_char = 7'h25;
			6'd7:  upper_char = 7'h5E;
			6'd8:  upper_char = 7'h26;
			6'd9:  upper_char = 7'h2A;
			6'd10: upper_char = 7'h28;
			6'd11: upper_char = 7'h29;
			6'd12: upper_char = 7'h5F;
			6'd13: upper_char = 7'h2B;
			6'd14: upper_char = 7'h08;
			6'd15: upper_char = 7'h09;
			6'd16: upper_char = 7'h51;
			6'd17: upper_char = 7'h57;
			6'd18: upper_char = 7'h45;
			6'd19: upper_char = 7'h52;
			6'd20: upper_char = 7'h54;
			6'd21: upper_char = 7'h59;
			6'd22: upper_char = 7'h55;
			6'd23: upper_char = 7'h49;
			6'd24: upper_char = 7'h4F;
			6'd25: upper_char = 7'h50;
			6'd26: upper_char = 7'h7B;
			6'd27: upper_char = 7'h7D;
			6'd28: upper_char = 7'h0A;
			6'd30: upper_char = 7'h41;
			6'd31: upper_char = 7'h53;
			6'd32: upper_char = 7'h44;
			6'd33: upper_char = 7'h46;
			6'd34: upper_char = 7'h47;
			6'd35: upper_char = 7'h48;
			6'd36: upper_char = 7'h4A;
			6'd37: upper_char = 7'h4B;
			6'd38: upper_char = 7'h4C;
			6'd39: upper_char = 7'h3A;
			6'd40: upper_char = 7'h22;
			6'd41: upper_char = 7'h7E;
			6'd43: upper_char = 7'h7C;
			6'd44: upper_char = 7'h5A;
			6'd45: upper_char = 7'h58;
			6'd46: upper_char = 7'h43;
			6'd47: upper_char = 7'h56;
			6'd48: upper_char = 7'h42;
			6'd49: upper_char = 7'h4E;
			6'd50: upper_char = 7'h4D;
			6'd51: upper_char = 7'h3C;
			6'd52: upper_char = 7'h3E;
			6'd53: upper_char = 7'h3F;
			6'd55: upper_char = 7'h2A;
			6'd57: upper_char = 7'h20;
			default: upper_char = 7'h00;
		endcase
	endfunction

endpackage

FILE: rtl/s2a_decode.sv
// Scancode decoder: tracks the shift keys and maps set-1 make codes to ASCII.
// Depends on s2a_pkg for codes, tables and the push request type.
module s2a_decode (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic                                  operation,
	input  logic [s2a_pkg::CODE_W-1:0]            scan_byte,
	output s2a_pkg::push_t                        push
);

	logic                         shift_q;
	logic [s2a_pkg::CHAR_W-1:0]   ch;
	logic                         is_make;
	logic                         is_break;
	logic                         in_table;

	assign is_make  = (scan_byte == s2a_pkg::MAKE_LSHIFT) || (scan_byte == s2a_pkg::MAKE_RSHIFT);
	assign is_break = (scan_byte == s2a_pkg::BREAK_LSHIFT)
		|| (scan_byte == s2a_pkg::BREAK_RSHIFT);
	assign in_table = !scan_byte[7] && (scan_byte[6:0] < s2a_pkg::TABLE_LEN);

	always_comb begin
		ch = shift_q ? s2a_pkg::upper_char(scan_byte[5:0])
			: s2a_pkg::plain_char(scan_byte[5:0]);
		push.ch  = ch;
		push.req = (operation == s2a_pkg::OP_SCAN) && !is_make && !is_break && in_table
			&& (ch != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 1'b0;
		end else if (accept && (operation == s2a_pkg::OP_SCAN)) begin
			if (is_make) begin
				shift_q <= 1'b1;
			end else if (is_break) begin
				shift_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/s2a_ring.sv
// Character ring buffer: one synchronous memory plus read and write pointers.
// Registers the result of each accepted word. Depends on s2a_pkg.
module s2a_ring #(
	parameter int FIFO_DEPTH = s2a_pkg::FIFO_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 operation,
	input  s2a_pkg::push_t       push,
	output s2a_pkg::result_t     res_s1
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(FIFO_DEPTH - 1);

	logic [s2a_pkg::CHAR_W-1:0] mem [FIFO_DEPTH];
	logic [s2a_pkg::CHAR_W-1:0] rdata_s1;
	logic [PTR_W-1:0]           wp_q;
	logic [PTR_W-1:0]           rp_q;
	logic [PTR_W-1:0]           wp_inc;
	logic [PTR_W-1:0]           rp_inc;
	logic [PTR_W-1:0]           wp_nxt;
	logic [PTR_W-1:0]           rp_nxt;
	logic                       push_ok;
	logic                       pop_ok;
	logic                       pop_s1;
	logic                       waiting_s1;

	assign wp_inc  = (wp_q == LAST) ? '0 : wp_q + 1'b1;
	assign rp_inc  = (rp_q == LAST) ? '0 : rp_q + 1'b1;
	assign push_ok = accept && push.req && (wp_inc != rp_q);
	assign pop_ok  = accept && (operation == s2a_pkg::OP_POP) && (wp_q != rp_q);
	assign wp_nxt  = push_ok ? wp_inc : wp_q;
	assign rp_nxt  = pop_ok ? rp_inc : rp_q;

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wp_q] <= push.ch;
		end
		if (pop_ok) begin
			rdata_s1 <= mem[rp_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			pop_s1     <= 1'b0;
			waiting_s1 <= 1'b0;
		end else if (accept) begin
			wp_q       <= wp_nxt;
			rp_q       <= rp_nxt;
			pop_s1     <= pop_ok;
			waiting_s1 <= (wp_nxt != rp_nxt);
		end
	end

	always_comb begin
		res_s1.char_valid  = pop_s1;
		res_s1.key_waiting = waiting_s1;
		res_s1.character   = pop_s1 ? rdata_s1 : '0;
	end

endmodule

FILE: rtl/s2a_outbuf.sv
// Output stage with skid register: holds the result word while the receiver stalls.
// Depends on s2a_pkg for the result type.
module s2a_outbuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  s2a_pkg::result_t     res_s1,
	input  logic                 out_stall,
	output logic                 in_stall,
	output logic                 out_valid,
	output s2a_pkg::result_t     out_res
);

	logic             valid_s1;
	logic             skid_valid_q;
	s2a_pkg::result_t skid_q;

	assign in_stall  = skid_valid_q && valid_s1;
	assign out_valid = skid_valid_q || valid_s1;
	assign out_res   = skid_valid_q ? skid_q : res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!skid_valid_q || !valid_s1) begin
				valid_s1 <= accept;
			end
			if (skid_valid_q) begin
				if (!out_stall) begin
					skid_valid_q <= 1'b0;
				end
			end else if (valid_s1 && out_stall) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q && valid_s1 && out_stall) begin
			skid_q <= res_s1;
		end
	end

endmodule

FILE: rtl/scancode_to_ascii_fifo_top.sv
// Set-1 scancode to ASCII converter with a character FIFO.
// Input channel: in_valid/in_stall with operation (0 = scancode byte, 1 = pop)
// and scan_byte. Output channel: out_valid/out_stall with character,
// char_valid and key_waiting; exactly one output word per input word, in order.
// Shift make/break codes update the shift state; other make codes below 59
// with a nonzero table entry push one character, dropped when the FIFO is full.
// The FIFO holds at most FIFO_DEPTH-1 characters.
// Each taken input word's result is registered before it reaches the output.
// Throughput: one word per cycle while in_stall is low; the memory has one
// write and one read port, and each word does at most one of the two.
// A stalled output word waits in a skid register while one more input word
// is taken; in_stall rises only when both output stage and skid are full.
// Reset (arst_n low) empties the FIFO and clears the shift state; the
// character memory itself is not cleared.
// Depends on s2a_pkg, s2a_decode, s2a_ring and s2a_outbuf.
module scancode_to_ascii_fifo_top #(
	parameter int FIFO_DEPTH = s2a_pkg::FIFO_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic [s2a_pkg::CODE_W-1:0]       scan_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [s2a_pkg::CHAR_W-1:0]       character,
	output logic                             char_valid,
	output logic                             key_waiting
);

	logic             accept;
	s2a_pkg::push_t   push;
	s2a_pkg::result_t res_s1;
	s2a_pkg::result_t out_res;

	assign accept = in_valid && !in_stall;

	s2a_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.scan_byte (scan_byte),
		.push      (push)
	);

	s2a_ring #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (operation),
		.push      (push),
		.res_s1    (res_s1)
	);

	s2a_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.res_s1    (res_s1),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign character   = out_res.character;
	assign char_valid  = out_res.char_valid;
	assign key_waiting = out_res.key_waiting;

endmodule

FILE: rtl/s2a_checker.sv
// Port-level checker for the scancode to ASCII FIFO, bound to the top level.
// Depends on s2a_pkg for widths.
module s2a_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        operation,
	input logic [s2a_pkg::CODE_W-1:0]  scan_byte,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [s2a_pkg::CHAR_W-1:0]  character,
	input logic                        char_valid,
	input logic                        key_waiting
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(character)
			&& $stable(char_valid) && $stable(key_waiting))
		else $error("stalled output word changed");

	a_no_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> character == '0)
		else $error("character nonzero without char_valid");

	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no output word pending");

	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || !out_stall |=> !in_stall)
		else $error("input stall persists after output drained");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(operation) && $stable(scan_byte))
		else $error("stalled input word changed");

endmodule

bind scancode_to_ascii_fifo_top s2a_checker u_s2a_checker (.*);
